### sv/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared codes and constants for the linear blend vertex skinning block.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_INFL = 2'd1;
  localparam logic [1:0] KIND_PASS = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIX_DIAGONAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_W_ONE    = 2'd2;

  localparam logic [3:0] ELEMS_PER_BONE = 4'd12;
  localparam logic [3:0] ELEM_DIAG_11   = 4'd5;
  localparam logic [3:0] ELEM_DIAG_22   = 4'd10;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic [15:0] THRESHOLD_RST = 16'd1;

endpackage

### sv/lbvs_if.sv
// ----------------------------------------------------------------------------
// lbvs interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface lbvs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  bone_index;
  logic [3:0]  element_index;
  logic [31:0] matrix_value;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] norm_x;
  logic [31:0] norm_y;
  logic [31:0] norm_z;
  logic [16:0] weight;
  logic        last_influence;

  modport source (
    output valid, kind, bone_index, element_index, matrix_value,
    output pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, weight, last_influence,
    input  ready
  );
  modport sink (
    input  valid, kind, bone_index, element_index, matrix_value,
    input  pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, weight, last_influence,
    output ready
  );
endinterface

interface lbvs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pos_x;
  logic [31:0] out_pos_y;
  logic [31:0] out_pos_z;
  logic [31:0] out_norm_x;
  logic [31:0] out_norm_y;
  logic [31:0] out_norm_z;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z,
    output out_norm_x, out_norm_y, out_norm_z,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z,
    input  out_norm_x, out_norm_y, out_norm_z,
    output ready
  );
endinterface

interface lbvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/lbvs_bone_store.sv
// ----------------------------------------------------------------------------
// lbvs_bone_store
// Bone matrix memory. Conditions elements on write, registered read port.
// ----------------------------------------------------------------------------
module lbvs_bone_store #(
  parameter int unsigned DEPTH = 768,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    welem_i,
  input  logic [31:0]   wvalue_i,
  input  logic [15:0]   threshold_i,
  input  logic          fix_diag_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  import lbvs_pkg::*;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  logic        diag;
  logic [31:0] val_fix;
  logic [31:0] mag;
  logic [31:0] val_cond;

  always_comb begin
    diag = (welem_i == ELEM_DIAG_11) || (welem_i == ELEM_DIAG_22);
    val_fix = wvalue_i;
    if (fix_diag_i && diag && wvalue_i[31]) begin
      val_fix = (wvalue_i == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - wvalue_i);
    end
    mag = val_fix[31] ? (32'd0 - val_fix) : val_fix;
    val_cond = (mag < {16'd0, threshold_i}) ? 32'd0 : val_fix;
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= val_cond;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/linear_blend_vertex_skinning_top.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Load items are written to the bone store on acceptance; pass items go
// through S_EMIT to the output register. An influence runs 6 rows of 8 steps
// through one 33x33 multiplier (3 matrix products, then 2 weight products per
// row); after the last influence, S_EMIT loads the output register.
// One item in flight; a result may wait in the output register meanwhile.
// Reset clears control state and sums, presets config; bone store not reset.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_top #(
  parameter int unsigned MAX_BONES = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbvs_in_if.sink    in_i,
  lbvs_out_if.source out_o,
  lbvs_cfg_if.sink   cfg_i
);
  import lbvs_pkg::*;

  localparam int unsigned DEPTH = MAX_BONES * 12;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [2:0] STEP_M0   = 3'd1;
  localparam logic [2:0] STEP_M1   = 3'd2;
  localparam logic [2:0] STEP_M2   = 3'd3;
  localparam logic [2:0] STEP_M3   = 3'd4;
  localparam logic [2:0] STEP_WHI  = 3'd5;
  localparam logic [2:0] STEP_WLO  = 3'd6;
  localparam logic [2:0] STEP_LAST = 3'd7;

  logic [1:0]  state_q, state_d;
  logic [2:0]  step_q;
  logic [1:0]  row_q;
  logic        vec_q;
  logic        pass_q;
  logic        last_q;

  logic [15:0] thr_q;
  logic        fix_q;
  logic        nw_q;

  logic [AW-1:0]      base_q;
  logic [16:0]        w_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nrm_q [3];

  logic signed [47:0] t_q;
  logic signed [47:0] sums_q [2][3];
  logic signed [65:0] mul_q;

  logic        out_valid_q;
  logic [31:0] out_q [6];

  logic              in_acc;
  logic              bone_ok;
  logic              elem_ok;
  logic [9:0]        bone12;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;
  logic [16:0]       w_sat;
  logic [1:0]        vsel;
  logic signed [31:0] vcur;
  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic signed [65:0] mul_shr;
  logic signed [47:0] m3_ext;
  logic              wsel;
  logic              run_done;
  logic              emit_go;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign bone_ok    = int'(in_i.bone_index) < MAX_BONES;
  assign elem_ok    = in_i.element_index < ELEMS_PER_BONE;
  assign bone12     = {1'b0, in_i.bone_index, 3'd0} + {2'd0, in_i.bone_index, 2'd0};
  assign w_sat      = (in_i.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_i.weight;
  assign raddr      = base_q + AW'({row_q, step_q[1:0]});

  lbvs_bone_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i       (clk_i),
    .we_i        (in_acc && (in_i.kind == KIND_LOAD) && bone_ok && elem_ok),
    .waddr_i     (AW'(bone12) + AW'(in_i.element_index)),
    .welem_i     (in_i.element_index),
    .wvalue_i    (in_i.matrix_value),
    .threshold_i (thr_q),
    .fix_diag_i  (fix_q),
    .raddr_i     (raddr),
    .rdata_o     (rdata)
  );

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      fix_q <= 1'b1;
      nw_q  <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SMALL_THRESHOLD: thr_q <= cfg_i.data[15:0];
        CFG_FIX_DIAGONAL:    fix_q <= cfg_i.data[0];
        CFG_NORMAL_W_ONE:    nw_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    vsel = 2'(step_q - STEP_M0);
    vcur = vec_q ? nrm_q[vsel] : pos_q[vsel];
    op_a = {rdata[31], rdata};
    op_b = {vcur[31], vcur};
    case (step_q)
      STEP_WHI: begin
        op_a = {t_q[47], t_q[47:16]};
        op_b = {16'd0, w_q};
      end
      STEP_WLO: begin
        op_a = {17'd0, t_q[15:0]};
        op_b = {16'd0, w_q};
      end
      default: ;
    endcase
  end

  assign mul_shr  = mul_q >>> FRAC_BITS;
  assign wsel     = !vec_q || nw_q;
  assign m3_ext   = wsel ? {{16{rdata[31]}}, rdata} : 48'sd0;
  assign run_done = (step_q == STEP_LAST) && (row_q == 2'd2) && vec_q;
  assign emit_go  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    mul_q <= op_a * op_b;
    if (in_acc) begin
      base_q   <= AW'(bone12);
      w_q      <= w_sat;
      pos_q[0] <= in_i.pos_x;
      pos_q[1] <= in_i.pos_y;
      pos_q[2] <= in_i.pos_z;
      nrm_q[0] <= in_i.norm_x;
      nrm_q[1] <= in_i.norm_y;
      nrm_q[2] <= in_i.norm_z;
    end
    if (state_q == S_RUN) begin
      case (step_q)
        STEP_M1: t_q <= mul_shr[47:0];
        STEP_M2: t_q <= t_q + mul_shr[47:0];
        STEP_M3: t_q <= t_q + mul_shr[47:0] + m3_ext;
        default: ;
      endcase
    end
    if ((state_q == S_EMIT) && emit_go) begin
      for (int i = 0; i < 3; i++) begin
        out_q[i]     <= pass_q ? pos_q[i] : sums_q[0][i][31:0];
        out_q[3 + i] <= pass_q ? nrm_q[i] : sums_q[1][i][31:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == KIND_PASS) begin
            state_d = S_EMIT;
          end else if (in_i.kind == KIND_INFL) begin
            if (bone_ok) begin
              state_d = S_RUN;
            end else if (in_i.last_influence) begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_RUN: begin
        if (run_done) begin
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 3'd0;
      row_q       <= 2'd0;
      vec_q       <= 1'b0;
      pass_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int v = 0; v < 2; v++) begin
        for (int r = 0; r < 3; r++) begin
          sums_q[v][r] <= 48'sd0;
        end
      end
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pass_q <= (in_i.kind == KIND_PASS);
        last_q <= in_i.last_influence;
        step_q <= 3'd0;
        row_q  <= 2'd0;
        vec_q  <= 1'b0;
      end
      if (state_q == S_RUN) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_LAST) begin
          row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
          if (row_q == 2'd2) begin
            vec_q <= !vec_q;
          end
        end
        if (step_q == STEP_WLO) begin
          sums_q[vec_q][row_q] <= sums_q[vec_q][row_q] + mul_q[47:0];
        end
        if (step_q == STEP_LAST) begin
          sums_q[vec_q][row_q] <= sums_q[vec_q][row_q] + {31'd0, mul_q[32:16]};
        end
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_EMIT) && emit_go) begin
        out_valid_q <= 1'b1;
        if (!pass_q) begin
          for (int v = 0; v < 2; v++) begin
            for (int r = 0; r < 3; r++) begin
              sums_q[v][r] <= 48'sd0;
            end
          end
        end
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_pos_x  = out_q[0];
  assign out_o.out_pos_y  = out_q[1];
  assign out_o.out_pos_z  = out_q[2];
  assign out_o.out_norm_x = out_q[3];
  assign out_o.out_norm_y = out_q[4];
  assign out_o.out_norm_z = out_q[5];

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_blend_vertex_skinning_top. Bone matrices are
// loaded ahead of use, then a short table of corner items is replayed before
// random phases of vertex blends, element loads, pass items and junk items
// under several register settings. A bit-accurate Q16.16 skinning predictor
// checks each result not given by a table row; both channels idle at random,
// and one phase parks the result side long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import lbvs_pkg::*;

  localparam int NUM_BONES = 64;
  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES = 6;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  bone;
    logic [3:0]  elem;
    logic [31:0] mval;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [16:0] weight;
    logic        last;
  } vert_item_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } skin_res_t;

  typedef struct {
    vert_item_t it;
    bit         typed;
    skin_res_t  res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  lbvs_in_if  in_if ();
  lbvs_out_if out_if ();
  lbvs_cfg_if cfg_if ();

  linear_blend_vertex_skinning_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic signed [31:0] bone_mem [NUM_BONES*12];
  bit                 elem_loaded [NUM_BONES*12];
  longint             pos_acc [3];
  longint             nrm_acc [3];
  logic [15:0]        thr_reg;
  bit                 fix_diag_reg;
  bit                 w_one_reg;

  skin_res_t skin_expect [$];
  dir_row_t  dir_rows [$];
  int        mismatch_cnt = 0;
  int        items_sent = 0;
  longint    cycle_cnt = 0;
  bit        idle_on = 1'b1;
  bit        hold_off_go = 1'b0;
  string     fld_name [6] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                              "out_norm_x", "out_norm_y", "out_norm_z"};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- skinning predictor ----------------

  function automatic longint wrap48(longint x);
    logic signed [47:0] s;
    s = x[47:0];
    return longint'(s);
  endfunction

  function automatic logic [31:0] condition_elem(logic [3:0] e, logic [31:0] raw);
    longint v;
    longint mag;
    v = longint'($signed(raw));
    if (fix_diag_reg && (e == ELEM_DIAG_11 || e == ELEM_DIAG_22) && v < 0)
      v = (raw == Q_MIN) ? longint'(Q_MAX) : -v;
    mag = (v < 0) ? -v : v;
    if (mag < longint'(thr_reg)) v = 0;
    return v[31:0];
  endfunction

  function automatic longint row_term(int base, int r, longint v0, longint v1,
                                      longint v2, bit w1, longint wt);
    longint t;
    t = ((longint'(bone_mem[base+4*r]) * v0) >>> FRAC)
      + ((longint'(bone_mem[base+4*r+1]) * v1) >>> FRAC)
      + ((longint'(bone_mem[base+4*r+2]) * v2) >>> FRAC);
    if (w1) t += longint'(bone_mem[base+4*r+3]);
    t = wrap48(t);
    return (t * wt) >>> 16;
  endfunction

  function automatic bit predict_skin(input vert_item_t it, output skin_res_t res);
    longint vp [3];
    longint vn [3];
    longint wt;
    int     base;
    bit     got;
    got = 1'b0;
    res = '0;
    base = int'(it.bone) * int'(ELEMS_PER_BONE);
    vp[0] = longint'($signed(it.pos_x));
    vp[1] = longint'($signed(it.pos_y));
    vp[2] = longint'($signed(it.pos_z));
    vn[0] = longint'($signed(it.norm_x));
    vn[1] = longint'($signed(it.norm_y));
    vn[2] = longint'($signed(it.norm_z));
    case (it.kind)
      KIND_LOAD: begin
        if (it.elem < ELEMS_PER_BONE) begin
          bone_mem[base + int'(it.elem)] = condition_elem(it.elem, it.mval);
          elem_loaded[base + int'(it.elem)] = 1'b1;
        end
      end
      KIND_PASS: begin
        res = '{it.pos_x, it.pos_y, it.pos_z, it.norm_x, it.norm_y, it.norm_z};
        got = 1'b1;
      end
      KIND_INFL: begin
        wt = (it.weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(it.weight);
        for (int r = 0; r < 3; r++) begin
          pos_acc[r] = wrap48(pos_acc[r] + row_term(base, r, vp[0], vp[1], vp[2],
                                                    1'b1, wt));
          nrm_acc[r] = wrap48(nrm_acc[r] + row_term(base, r, vn[0], vn[1], vn[2],
                                                    w_one_reg, wt));
        end
        if (it.last) begin
          res = '{pos_acc[0][31:0], pos_acc[1][31:0], pos_acc[2][31:0],
                  nrm_acc[0][31:0], nrm_acc[1][31:0], nrm_acc[2][31:0]};
          pos_acc = '{0, 0, 0};
          nrm_acc = '{0, 0, 0};
          got = 1'b1;
        end
      end
      default: got = 1'b0;
    endcase
    return got;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic vert_item_t item_of(logic [1:0] kind, logic [5:0] bone,
      logic [3:0] elem, logic [31:0] mval, logic [31:0] px, logic [31:0] py,
      logic [31:0] pz, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
      logic [16:0] w, logic last);
    return '{kind, bone, elem, mval, px, py, pz, nx, ny, nz, w, last};
  endfunction

  function automatic skin_res_t res_of(logic [31:0] px, logic [31:0] py,
      logic [31:0] pz, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    return '{px, py, pz, nx, ny, nz};
  endfunction

  function automatic void add_dir_row(input vert_item_t it, input bit typed,
                                      input skin_res_t res);
    dir_row_t row;
    row.it    = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic vert_item_t rand_item();
    return item_of(2'($urandom), 6'($urandom), 4'($urandom), $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   17'($urandom), 1'($urandom));
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!idle_on || pick < 65) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 99) < 70)
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    return $urandom;
  endfunction

  function automatic logic [16:0] rand_weight();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 20) return WEIGHT_ONE;
    if (pick < 26) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  // mostly plausible rotation/translation values, with tiny and extreme ones
  function automatic logic [31:0] elem_value(logic [3:0] e);
    int          pick;
    int          span;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    span = int'(thr_reg) + 2;
    if (pick < 8) begin
      v = $urandom;
    end else if (pick < 20) begin
      v = $urandom_range(0, span);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (pick < 24) begin
      v = Q_MIN;
    end else if (e[1:0] == 2'd3) begin
      v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    end else begin
      v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    end
    return v;
  endfunction

  function automatic bit bone_loaded(int b);
    for (int e = 0; e < 12; e++)
      if (!elem_loaded[b*12 + e]) return 1'b0;
    return 1'b1;
  endfunction

  // valid stays high across back-to-back items; it drops only ahead of a gap
  task automatic send_item(input vert_item_t it, input bit typed = 1'b0,
                           input skin_res_t typed_res = '0);
    int        gap;
    skin_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.kind           <= it.kind;
    in_if.bone_index     <= it.bone;
    in_if.element_index  <= it.elem;
    in_if.matrix_value   <= it.mval;
    in_if.pos_x          <= it.pos_x;
    in_if.pos_y          <= it.pos_y;
    in_if.pos_z          <= it.pos_z;
    in_if.norm_x         <= it.norm_x;
    in_if.norm_y         <= it.norm_y;
    in_if.norm_z         <= it.norm_z;
    in_if.weight         <= it.weight;
    in_if.last_influence <= it.last;
    in_if.valid          <= 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (predict_skin(it, r))
      skin_expect.insert(skin_expect.size(), typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (skin_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [15:0] thr, input bit fix, input bit w_one);
    logic [31:0] data;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          data = {16'($urandom), thr};
          cfg_if.index <= CFG_SMALL_THRESHOLD;
        end
        1: begin
          data = {31'($urandom), fix};
          cfg_if.index <= CFG_FIX_DIAGONAL;
        end
        default: begin
          data = {31'($urandom), w_one};
          cfg_if.index <= CFG_NORMAL_W_ONE;
        end
      endcase
      cfg_if.data  <= data;
      cfg_if.valid <= 1'b1;
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      case (i)
        0:       thr_reg = data[15:0];
        1:       fix_diag_reg = data[0];
        default: w_one_reg = data[0];
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_bone(input int b);
    vert_item_t it;
    for (int e = 0; e < 12; e++) begin
      it = rand_item();
      it.kind = KIND_LOAD;
      it.bone = 6'(b);
      it.elem = 4'(e);
      it.mval = elem_value(it.elem);
      send_item(it);
    end
  endtask

  task automatic ensure_bone(input int b);
    if (!bone_loaded(b)) load_bone(b);
  endtask

  task automatic run_vertex(input bit mark_last);
    int         n;
    int         b;
    vert_item_t it;
    n = $urandom_range(1, 4);
    it = rand_item();
    it.kind   = KIND_INFL;
    it.pos_x  = rand_coord();
    it.pos_y  = rand_coord();
    it.pos_z  = rand_coord();
    it.norm_x = rand_coord();
    it.norm_y = rand_coord();
    it.norm_z = rand_coord();
    for (int k = 0; k < n; k++) begin
      b = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                      : $urandom_range(0, NUM_BONES-1);
      ensure_bone(b);
      it.bone   = 6'(b);
      it.elem   = 4'($urandom);
      it.mval   = $urandom;
      it.weight = rand_weight();
      it.last   = mark_last && (k == n-1);
      send_item(it);
    end
  endtask

  task automatic run_sequence();
    int         pick;
    vert_item_t it;
    pick = $urandom_range(0, 99);
    it = rand_item();
    if (pick < 58) begin
      run_vertex(pick < 54);
    end else if (pick < 66) begin
      load_bone($urandom_range(0, NUM_BONES-1));
    end else if (pick < 80) begin
      it.kind = KIND_LOAD;
      it.elem = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                             : 4'($urandom_range(12, 15));
      it.mval = elem_value(it.elem);
      send_item(it);
    end else if (pick < 94) begin
      it.kind = KIND_PASS;
      send_item(it);
    end else begin
      it.kind = KIND_UNUSED;
      send_item(it);
    end
  endtask

  // ---------------- result side ----------------

  initial begin : receiver
    int stall_left;
    out_if.ready = 1'b0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_off_go) begin
        hold_off_go = 1'b0;
        stall_left = HOLD_OFF_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_cnt < 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : result_check
    skin_res_t got;
    skin_res_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.out_pos_x, out_if.out_pos_y, out_if.out_pos_z,
              out_if.out_norm_x, out_if.out_norm_y, out_if.out_norm_z};
      if (skin_expect.size() == 0) begin
        note_mismatch("unexpected item, out_pos_x", 'x, got.px);
      end else begin
        want = skin_expect.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[32*(5-i) +: 32] !== want[32*(5-i) +: 32])
            note_mismatch(fld_name[i], want[32*(5-i) +: 32], got[32*(5-i) +: 32]);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin : stimulus
    int phase_end;
    rst_ni = 1'b0;
    in_if.valid          = 1'b0;
    in_if.kind           = KIND_LOAD;
    in_if.bone_index     = '0;
    in_if.element_index  = '0;
    in_if.matrix_value   = '0;
    in_if.pos_x          = '0;
    in_if.pos_y          = '0;
    in_if.pos_z          = '0;
    in_if.norm_x         = '0;
    in_if.norm_y         = '0;
    in_if.norm_z         = '0;
    in_if.weight         = '0;
    in_if.last_influence = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SMALL_THRESHOLD;
    cfg_if.data  = '0;
    thr_reg      = THRESHOLD_RST;
    fix_diag_reg = 1'b1;
    w_one_reg    = 1'b1;
    pos_acc      = '{0, 0, 0};
    nrm_acc      = '{0, 0, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_bone(0);

    add_dir_row(item_of(KIND_PASS, 6'd0, 4'd0, '0,
        Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 17'h1ffff, 1'b1),
        1'b1, res_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    add_dir_row(item_of(KIND_PASS, 6'd63, 4'd15, Q_MAX,
        Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, 1'b0),
        1'b1, res_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    add_dir_row(item_of(KIND_PASS, 6'd5, 4'd3, Q_MIN,
        32'd1, 32'hffff_ffff, '0, Q_ONE, -Q_ONE, 32'h1234_5678, WEIGHT_ONE, 1'b1),
        1'b1, res_of(32'd1, 32'hffff_ffff, '0, Q_ONE, -Q_ONE, 32'h1234_5678));
    // zero weight on the first vertex after reset leaves every sum at zero
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_MAX, Q_ONE, '0, 1'b1),
        1'b1, res_of('0, '0, '0, '0, '0, '0));
    add_dir_row(item_of(KIND_LOAD, 6'd0, ELEM_DIAG_11, 32'hffff_0000,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, ELEM_DIAG_22, Q_MIN,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, 4'd0, '0,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, 4'd3, Q_MAX,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, 4'd11, Q_MIN,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, ELEMS_PER_BONE, 32'd12345,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd63, 4'd15, Q_MAX,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_UNUSED, 6'd0, 4'd0, Q_MIN,
        Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, WEIGHT_ONE, 1'b1), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_ONE, Q_ONE, Q_ONE, '0, Q_ONE, '0, WEIGHT_ONE, 1'b0), 1'b0, '0);
    // a pass item mid-vertex must not disturb the sums
    add_dir_row(item_of(KIND_PASS, 6'd0, 4'd0, '0,
        32'd7, 32'd8, 32'd9, 32'd10, 32'd11, 32'd12, '0, 1'b1),
        1'b1, res_of(32'd7, 32'd8, 32'd9, 32'd10, 32'd11, 32'd12));
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_ONE, -Q_ONE, Q_ONE, Q_ONE, '0, '0, 17'h1ffff, 1'b1), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, WEIGHT_ONE, 1'b1), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 17'd1, 1'b1), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 17'd32768, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 17'd32768, 1'b1), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, 4'd1, 32'd1,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_LOAD, 6'd0, 4'd2, 32'hffff_ffff,
        '0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b0, '0);
    add_dir_row(item_of(KIND_INFL, 6'd0, 4'd0, '0,
        32'h0003_0000, 32'hfffe_0000, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
        WEIGHT_ONE, 1'b1), 1'b0, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       write_regs(16'd0, 1'b1, 1'b1);
        1:       write_regs(16'hffff, 1'b0, 1'b0);
        2:       write_regs(THRESHOLD_RST, 1'b1, 1'b0);
        3:       write_regs(16'($urandom_range(0, 300)), 1'($urandom), 1'($urandom));
        4:       write_regs(16'd16, 1'b0, 1'b1);
        default: write_regs(16'($urandom), 1'b1, 1'b1);
      endcase
      // one phase runs without gaps and opens with a long result-side hold-off
      idle_on = (p != 1);
      hold_off_go = (p == 1);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_sequence();
      drain_results();
    end

    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
